>>> src/swog_pkg.sv
// Shared constants, types and command/status bundles for the onset grouping block.
`timescale 1ns / 1ps

package swog_pkg;

	// Frame geometry and coefficient format.
	localparam int WINDOWS    = 8;
	localparam int MAX_BANDS  = 16;
	localparam int WINDOW_LEN = 128;
	localparam int COEFF_BITS = 24;

	// Derived widths.
	localparam int WIN_W      = $clog2(WINDOWS);
	localparam int BAND_IDX_W = $clog2(MAX_BANDS);
	localparam int POS_W      = $clog2(WINDOW_LEN);
	localparam int SQ_W       = 2 * COEFF_BITS;

	// Fixed field and register widths.
	localparam int E_W        = 56;
	localparam int BAND_NUM_W = 5;
	localparam int LEN_W      = 4;
	localparam int CUTOFF_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// First band that takes part in the onset vote.
	localparam int FIRST_BAND = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BANDS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEREO    = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [BAND_NUM_W-1:0] MAX_BANDS_RST = 5'd14;
	localparam logic [CUTOFF_W-1:0]   CUTOFF_RST    = 8'd128;

	typedef struct packed {
		logic [BAND_NUM_W-1:0] max_bands;
		logic [CUTOFF_W-1:0]   cutoff;
		logic                  stereo;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;     // register the squares of an accepted item
		logic accumulate;  // add into the band sum, close a band if marked
		logic win_init;    // start the per-band pass at the first voting band
		logic pass_step;   // process one band entry
		logic restart;     // pass copies energies into min and max
		logic load_onset;  // emit the onset group and restart the group
		logic win_done;    // finish the window, emit the final group if last
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic wend;         // captured item closes a window
		logic pass_empty;   // no voting bands at the current band limit
		logic pass_last;    // current pass entry is the last voting band
		logic new_group;    // current window opens a group
		logic onset;        // vote count is above the quorum
		logic last_window;  // current window is the last of the frame
		logic out_free;     // output register can take a result
	} sts_t;

endpackage

>>> src/swog_ctrl.sv
// Controller state machine that sequences items, band passes and result loads.
`timescale 1ns / 1ps

module swog_ctrl
	import swog_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_WIN,
		ST_PASS,
		ST_DECIDE,
		ST_ONSET,
		ST_FINAL
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   restart_q;
	logic   restart_next;

	always_comb begin
		state_next   = state_q;
		restart_next = restart_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.restart  = restart_q;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_next = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.accumulate = 1'b1;
				state_next     = sts.wend ? ST_WIN : ST_IDLE;
			end
			ST_WIN: begin
				cmd.win_init = 1'b1;
				restart_next = sts.new_group;
				if (sts.pass_empty) begin
					state_next = sts.new_group ? ST_FINAL : ST_DECIDE;
				end else begin
					state_next = ST_PASS;
				end
			end
			ST_PASS: begin
				cmd.pass_step = 1'b1;
				if (sts.pass_last) begin
					state_next = restart_q ? ST_FINAL : ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_next = sts.onset ? ST_ONSET : ST_FINAL;
			end
			ST_ONSET: begin
				// An onset implies at least one voting band, so the pass is never empty.
				if (sts.out_free) begin
					cmd.load_onset = 1'b1;
					restart_next   = 1'b1;
					state_next     = ST_PASS;
				end
			end
			ST_FINAL: begin
				if (!sts.last_window || sts.out_free) begin
					cmd.win_done = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			restart_q <= 1'b0;
		end else begin
			state_q   <= state_next;
			restart_q <= restart_next;
		end
	end

endmodule

>>> src/swog_dp.sv
// Datapath: squaring, band energy sums, per-band running extremes, votes and result register.
`timescale 1ns / 1ps

module swog_dp
	import swog_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfg_t                         cfg,
	input  cmd_t                         cmd,
	output sts_t                         sts,
	input  logic signed [COEFF_BITS-1:0] coeff_left,
	input  logic signed [COEFF_BITS-1:0] coeff_right,
	input  logic                         band_end,
	input  logic                         window_end,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [LEN_W-1:0]             group_length,
	output logic                         last_group
);

	localparam int Q_W = BAND_NUM_W + 2;

	// Item capture.
	logic [SQ_W-1:0] sq_left_s1;
	logic [SQ_W-1:0] sq_right_s1;
	logic            bend_s1;
	logic            wend_s1;

	// Window state.
	logic [E_W-1:0]        band_sum_q;
	logic [BAND_NUM_W-1:0] band_num_q;
	logic [POS_W-1:0]      pos_q;
	logic [WIN_W-1:0]      win_num_q;
	logic [WIN_W-1:0]      first_win_q;
	logic [BAND_NUM_W-1:0] vote_q;
	logic [BAND_IDX_W-1:0] idx_q;

	logic [E_W-1:0]       energy_q [MAX_BANDS];
	logic [MAX_BANDS-1:0] energy_vld_q;
	logic [E_W-1:0]       min_q [MAX_BANDS];
	logic [E_W-1:0]       max_q [MAX_BANDS];

	// Output register.
	logic             out_valid_q;
	logic [LEN_W-1:0] out_len_q;
	logic             out_last_q;

	logic [COEFF_BITS-1:0] mag_left;
	logic [COEFF_BITS-1:0] mag_right;
	logic                  in_window;
	logic [SQ_W:0]         item_energy;
	logic [E_W:0]          sum_wide;
	logic [E_W-1:0]        sum_sat;
	logic [BAND_NUM_W-1:0] lim;
	logic [BAND_NUM_W-1:0] active;
	logic [Q_W-1:0]        quorum_wide;
	logic [BAND_NUM_W-1:0] quorum;
	logic [E_W-1:0]        cur_energy;
	logic [E_W-1:0]        cur_min;
	logic [E_W-1:0]        cur_max;
	logic [E_W-1:0]        new_min;
	logic [E_W-1:0]        new_max;
	logic [E_W+1:0]        min_x3;
	logic                  vote_hit;
	logic                  emit_final;
	logic                  out_load;
	logic [LEN_W-1:0]      load_len;

	// Two's-complement magnitude; the most negative value maps to 2^(COEFF_BITS-1).
	assign mag_left  = coeff_left[COEFF_BITS-1] ?
		(~coeff_left + 1'b1) : coeff_left;
	assign mag_right = coeff_right[COEFF_BITS-1] ?
		(~coeff_right + 1'b1) : coeff_right;
	assign in_window = {{(CUTOFF_W-POS_W){1'b0}}, pos_q} < cfg.cutoff;

	assign item_energy = {1'b0, sq_left_s1} + {1'b0, sq_right_s1};
	assign sum_wide    = {1'b0, band_sum_q} + {{(E_W-SQ_W){1'b0}}, item_energy};
	assign sum_sat     = sum_wide[E_W] ? {E_W{1'b1}} : sum_wide[E_W-1:0];

	assign lim         = (cfg.max_bands > BAND_NUM_W'(MAX_BANDS)) ?
		BAND_NUM_W'(MAX_BANDS) : cfg.max_bands;
	assign active      = (lim > BAND_NUM_W'(FIRST_BAND)) ?
		(lim - BAND_NUM_W'(FIRST_BAND)) : '0;
	assign quorum_wide = ({2'b00, active} * Q_W'(3)) >> 2;
	assign quorum      = quorum_wide[BAND_NUM_W-1:0];

	// One band entry per pass step.
	assign cur_energy = energy_vld_q[idx_q] ? energy_q[idx_q] : '0;
	assign cur_min    = min_q[idx_q];
	assign cur_max    = max_q[idx_q];
	assign new_min    = (cur_energy < cur_min) ? cur_energy : cur_min;
	assign new_max    = (cur_energy > cur_max) ? cur_energy : cur_max;
	assign min_x3     = {2'b00, new_min} + {1'b0, new_min, 1'b0};
	assign vote_hit   = {2'b00, new_max} > min_x3;

	assign emit_final = cmd.win_done && sts.last_window;
	assign out_load   = cmd.load_onset || emit_final;
	assign load_len   = cmd.load_onset ?
		(LEN_W'(win_num_q) - LEN_W'(first_win_q)) :
		(LEN_W'(WINDOWS) - LEN_W'(first_win_q));

	assign sts.wend        = wend_s1;
	assign sts.pass_empty  = lim <= BAND_NUM_W'(FIRST_BAND);
	assign sts.pass_last   = (BAND_NUM_W'(idx_q) + 1'b1) == lim;
	assign sts.new_group   = win_num_q == first_win_q;
	assign sts.onset       = vote_q > quorum;
	assign sts.last_window = win_num_q >= WIN_W'(WINDOWS - 1);
	assign sts.out_free    = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign group_length = out_len_q;
	assign last_group   = out_last_q;

	// Squares of the accepted item, zero past the cutoff.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sq_left_s1  <= in_window ? (mag_left * mag_left) : '0;
			sq_right_s1 <= (in_window && cfg.stereo) ? (mag_right * mag_right) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bend_s1 <= 1'b0;
			wend_s1 <= 1'b0;
		end else if (cmd.capture) begin
			bend_s1 <= band_end;
			wend_s1 <= window_end;
		end
	end

	// Band energy store; entries not written this window read as zero.
	always_ff @(posedge clk) begin
		if (cmd.accumulate && (bend_s1 || wend_s1) &&
		    (band_num_q < BAND_NUM_W'(MAX_BANDS))) begin
			energy_q[band_num_q[BAND_IDX_W-1:0]] <= sum_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_sum_q   <= '0;
			band_num_q   <= '0;
			pos_q        <= '0;
			win_num_q    <= '0;
			first_win_q  <= '0;
			vote_q       <= '0;
			idx_q        <= '0;
			energy_vld_q <= '0;
		end else begin
			if (cmd.accumulate) begin
				if (bend_s1 || wend_s1) begin
					band_sum_q <= '0;
					if (band_num_q < BAND_NUM_W'(MAX_BANDS)) begin
						energy_vld_q[band_num_q[BAND_IDX_W-1:0]] <= 1'b1;
					end
					if (band_num_q != {BAND_NUM_W{1'b1}}) begin
						band_num_q <= band_num_q + 1'b1;
					end
				end else begin
					band_sum_q <= sum_sat;
				end
				if (!wend_s1 && (pos_q != POS_W'(WINDOW_LEN - 1))) begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (cmd.win_init) begin
				idx_q  <= BAND_IDX_W'(FIRST_BAND);
				vote_q <= '0;
			end
			if (cmd.pass_step) begin
				idx_q <= idx_q + 1'b1;
				if (!cmd.restart && vote_hit) begin
					vote_q <= vote_q + 1'b1;
				end
			end
			if (cmd.load_onset) begin
				idx_q       <= BAND_IDX_W'(FIRST_BAND);
				first_win_q <= win_num_q;
			end
			if (cmd.win_done) begin
				if (sts.last_window) begin
					win_num_q   <= '0;
					first_win_q <= '0;
				end else begin
					win_num_q <= win_num_q + 1'b1;
				end
				energy_vld_q <= '0;
				band_sum_q   <= '0;
				band_num_q   <= '0;
				pos_q        <= '0;
			end
		end
	end

	// Running extremes since the group start.
	always_ff @(posedge clk) begin
		if (cmd.pass_step) begin
			if (cmd.restart) begin
				min_q[idx_q] <= cur_energy;
				max_q[idx_q] <= cur_energy;
			end else begin
				min_q[idx_q] <= new_min;
				max_q[idx_q] <= new_max;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_len_q  <= load_len;
			out_last_q <= emit_final;
		end
	end

endmodule

>>> src/short_window_onset_grouping.sv
// Top level of the short-window onset grouping block with its configuration registers.
`timescale 1ns / 1ps

// Short-window onset grouping.
// The input stream carries one spectral coefficient per transaction for eight short
// windows in a row: left coefficient, right coefficient, a band end flag in tuser and
// the window end mark in tlast. The output stream returns one transaction per closed
// group: its length in windows and, in tlast, whether it is the final group of the
// frame. The configuration channel writes max_bands, cutoff and stereo; it is always
// ready and is to be used only while the block is idle.
// An ordinary coefficient is squared on both channels when accepted, and its energy is
// then added into the band sum. A window end adds a setup state, a pass over the
// voting bands 2 to min(max_bands, 16) - 1 at one band per cycle through a single
// min/max/compare unit, a decide state and a closing state; the decide state is skipped
// when the window opens a group. An onset adds an onset state and a second pass over
// the same bands to restart the running values. A result is loaded into an output
// register; while the receiver stalls and that register is full, the next result waits
// and no input is taken, but once a result is parked the block goes on accepting
// coefficients. Reset clears all counters, the group state and the output register
// and restores max_bands 14, cutoff 128 and stereo off; no clearing pass runs.

module short_window_onset_grouping
	import swog_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [2*COEFF_BITS-1:0] s_axis_tdata,   // coeff_left, coeff_right
	input  logic                    s_axis_tuser,   // band_end
	input  logic                    s_axis_tlast,   // window_end
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [7:0]              m_axis_tdata,   // group_length, zero fill
	output logic                    m_axis_tlast,   // last_group
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	cfg_t             cfg_q;
	cmd_t             cmd;
	sts_t             sts;
	logic [LEN_W-1:0] group_length;

	// Configuration writes are registered; indexes beyond the list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_bands <= MAX_BANDS_RST;
			cfg_q.cutoff    <= CUTOFF_RST;
			cfg_q.stereo    <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAX_BANDS: cfg_q.max_bands <= cfg_data[BAND_NUM_W-1:0];
				CFG_CUTOFF:    cfg_q.cutoff    <= cfg_data[CUTOFF_W-1:0];
				CFG_STEREO:    cfg_q.stereo    <= cfg_data[0];
				default:       cfg_q           <= cfg_q;
			endcase
		end
	end

	swog_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	swog_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.sts          (sts),
		.coeff_left   (s_axis_tdata[COEFF_BITS-1:0]),
		.coeff_right  (s_axis_tdata[2*COEFF_BITS-1:COEFF_BITS]),
		.band_end     (s_axis_tuser),
		.window_end   (s_axis_tlast),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.group_length (group_length),
		.last_group   (m_axis_tlast)
	);

	assign m_axis_tdata = {{(8-LEN_W){1'b0}}, group_length};

	// An accepted coefficient is always followed by its accumulate cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted on two consecutive cycles");

	// Every group holds at least one and at most WINDOWS windows.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[LEN_W-1:0] != '0) &&
		(m_axis_tdata[LEN_W-1:0] <= LEN_W'(WINDOWS))))
		else $error("group length out of range");

	// A group closed by an onset never spans the whole frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tlast) |->
		(m_axis_tdata[LEN_W-1:0] < LEN_W'(WINDOWS)))
		else $error("onset group spans the whole frame");

endmodule

>>> sim/swog_group_checker.sv
// Checker for the onset grouping block: mirrors its behavior and compares the group results.
`timescale 1ns / 1ps

module swog_group_checker
	import swog_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	input  logic                    s_axis_tready,
	input  logic [2*COEFF_BITS-1:0] s_axis_tdata,
	input  logic                    s_axis_tuser,
	input  logic                    s_axis_tlast,
	input  logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	input  logic [7:0]              m_axis_tdata,
	input  logic                    m_axis_tlast,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output int                      mismatches,
	output int                      groups_open,
	output int                      groups_seen,
	output int                      onset_groups
);

	typedef struct packed {
		logic [LEN_W-1:0] length;
		logic             last;
	} group_t;

	localparam logic [E_W-1:0] E_SAT = '1;

	group_t pending_groups[$];

	cfg_t                  cfg;
	logic [E_W-1:0]        band_sum;
	logic [BAND_NUM_W-1:0] band_number;
	logic [POS_W-1:0]      position;
	logic [WIN_W-1:0]      window_number;
	logic [WIN_W-1:0]      first_win;
	logic [BAND_NUM_W-1:0] vote_count;
	logic [E_W-1:0]        window_energy [MAX_BANDS];
	logic [E_W-1:0]        running_min [MAX_BANDS];
	logic [E_W-1:0]        running_max [MAX_BANDS];

	function automatic logic [E_W-1:0] coeff_energy(logic [COEFF_BITS-1:0] c);
		logic [COEFF_BITS-1:0] mag;
		logic [E_W-1:0]        wide;
		mag = c[COEFF_BITS-1] ? (~c + 1'b1) : c;
		wide = E_W'(mag);
		return wide * wide;
	endfunction

	function automatic logic [E_W-1:0] energy_sum(logic [E_W-1:0] a, logic [E_W-1:0] b);
		logic [E_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[E_W] ? E_SAT : s[E_W-1:0];
	endfunction

	// Each voting band starts its running range from the current window.
	task automatic restart_ranges(int lim);
		int b;
		for (b = FIRST_BAND; b < lim; b++) begin
			running_min[b] = window_energy[b];
			running_max[b] = window_energy[b];
		end
	endtask

	task automatic absorb_coefficient(logic [COEFF_BITS-1:0] left, logic [COEFF_BITS-1:0] right,
			logic bend, logic wend);
		logic [E_W-1:0]        e;
		logic [E_W+1:0]        triple;
		logic [BAND_NUM_W-1:0] quorum;
		group_t                g;
		int                    lim;
		int                    active;
		int                    b;
		e = '0;
		if (position < cfg.cutoff) begin
			e = coeff_energy(left);
			if (cfg.stereo)
				e = energy_sum(e, coeff_energy(right));
		end
		band_sum = energy_sum(band_sum, e);

		// A window end closes the open band even without its own band mark.
		if (bend || wend) begin
			if (band_number < MAX_BANDS)
				window_energy[band_number[BAND_IDX_W-1:0]] = band_sum;
			band_sum = '0;
			if (band_number != '1)
				band_number++;
		end

		if (!wend) begin
			if (position < WINDOW_LEN - 1)
				position++;
			return;
		end

		lim = (cfg.max_bands > MAX_BANDS) ? MAX_BANDS : int'(cfg.max_bands);
		active = (lim > FIRST_BAND) ? lim - FIRST_BAND : 0;
		quorum = BAND_NUM_W'((active * 3) >> 2);

		if (window_number == first_win) begin
			restart_ranges(lim);
		end else begin
			vote_count = '0;
			for (b = FIRST_BAND; b < lim; b++) begin
				if (window_energy[b] < running_min[b])
					running_min[b] = window_energy[b];
				if (window_energy[b] > running_max[b])
					running_max[b] = window_energy[b];
				triple = {2'b00, running_min[b]} + {1'b0, running_min[b], 1'b0};
				if ({2'b00, running_max[b]} > triple)
					vote_count++;
			end
			if (vote_count > quorum) begin
				g.length = LEN_W'(window_number - first_win);
				g.last = 1'b0;
				pending_groups.push_back(g);
				first_win = window_number;
				restart_ranges(lim);
			end
		end

		if (window_number == WIN_W'(WINDOWS - 1)) begin
			g.length = LEN_W'(WINDOWS - int'(first_win));
			g.last = 1'b1;
			pending_groups.push_back(g);
			window_number = '0;
			first_win = '0;
		end else begin
			window_number++;
		end

		for (b = 0; b < MAX_BANDS; b++)
			window_energy[b] = '0;
		band_sum = '0;
		band_number = '0;
		position = '0;
	endtask

	task automatic compare_group();
		group_t g;
		groups_seen++;
		if (!m_axis_tlast)
			onset_groups++;
		if (pending_groups.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Unexpected group transaction: tdata 0x%02h last %b",
					m_axis_tdata, m_axis_tlast);
			return;
		end
		g = pending_groups.pop_front();
		if (m_axis_tdata !== {{(8-LEN_W){1'b0}}, g.length} || m_axis_tlast !== g.last) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Group %0d: expected length %0d last %b, got tdata 0x%02h last %b",
					groups_seen, g.length, g.last, m_axis_tdata, m_axis_tlast);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.max_bands = MAX_BANDS_RST;
			cfg.cutoff = CUTOFF_RST;
			cfg.stereo = 1'b0;
			band_sum = '0;
			band_number = '0;
			position = '0;
			window_number = '0;
			first_win = '0;
			vote_count = '0;
			for (int b = 0; b < MAX_BANDS; b++) begin
				window_energy[b] = '0;
				running_min[b] = '0;
				running_max[b] = '0;
			end
			pending_groups.delete();
			mismatches = 0;
			groups_open = 0;
			groups_seen = 0;
			onset_groups = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				compare_group();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MAX_BANDS: cfg.max_bands = cfg_data[BAND_NUM_W-1:0];
					CFG_CUTOFF:    cfg.cutoff = cfg_data[CUTOFF_W-1:0];
					CFG_STEREO:    cfg.stereo = cfg_data[0];
					default:       ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				absorb_coefficient(s_axis_tdata[COEFF_BITS-1:0],
					s_axis_tdata[2*COEFF_BITS-1:COEFF_BITS], s_axis_tuser, s_axis_tlast);
			groups_open = pending_groups.size();
		end
	end

endmodule

>>> sim/short_window_onset_grouping_tb.sv
// Testbench top for the onset grouping block: stimulus, idling patterns and the verdict.
`timescale 1ns / 1ps

// The run is split into eight phases. Each phase starts from an idle block with a new
// register setting and one of four idling patterns, then streams about one frame of
// eight short windows. Most windows are well formed (bands of one to three coefficients,
// band marks, a window end on the last one) with loud and quiet windows mixed so that
// onsets occur often. A minority are broken on purpose: stray marks, more band ends than
// the band counter holds, or windows longer than the window length. Every phase is
// padded out to a frame boundary, so a register write never lands in the middle of a
// frame. The checker beside the block predicts every group transaction and counts
// mismatches.

module short_window_onset_grouping_tb;
	import swog_pkg::*;

	// Cycles without any transaction before the run is declared hung.
	localparam int QUIET_LIMIT = 4000;
	// Settling time after the last expected group, covering the window pass.
	localparam int SETTLE_CYCLES = 64;

	typedef enum {LVL_ZERO, LVL_SOFT, LVL_FULL, LVL_EXTREME} level_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [2*COEFF_BITS-1:0] s_axis_tdata = '0;   // coeff_left, coeff_right
	logic                    s_axis_tuser = 1'b0; // band_end
	logic                    s_axis_tlast = 1'b0; // window_end
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [7:0]              m_axis_tdata;        // group_length, zero fill
	logic                    m_axis_tlast;        // last_group
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = CFG_MAX_BANDS;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	int mismatches;
	int groups_open;
	int groups_seen;
	int onset_groups;

	// Idling percentages for the sender and the receiver, set per phase.
	int send_idle = 0;
	int recv_stall = 0;

	int items_sent = 0;
	int frames_sent = 0;
	int win_mod = 0;
	int quiet_cycles = 0;

	always #4 clk = ~clk;

	short_window_onset_grouping dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	swog_group_checker grouping_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.groups_open   (groups_open),
		.groups_seen   (groups_seen),
		.onset_groups  (onset_groups)
	);

	// The receiver stalls at random, with the rate chosen by the current phase.
	always @(posedge clk) begin
		if (arst_n)
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
	end

	// Any transaction on any channel resets the hang counter.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", quiet_cycles);
				$display("short_window_onset_grouping: mismatch");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Coefficient values by loudness: zero, small signed, any value, or a corner value.
	function automatic logic [COEFF_BITS-1:0] pick_coeff(level_t lvl);
		logic [31:0] r;
		r = $urandom();
		case (lvl)
			LVL_ZERO: return '0;
			LVL_SOFT: return {{(COEFF_BITS-6){r[5]}}, r[5:0]};
			LVL_FULL: return r[COEFF_BITS-1:0];
			default: begin
				case (r[1:0])
					2'd0:    return 24'h800000;
					2'd1:    return 24'h7FFFFF;
					2'd2:    return 24'hFFFFFF;
					default: return 24'h000001;
				endcase
			end
		endcase
	endfunction

	// One coefficient transaction. Random idle cycles come first; a valid that stays
	// high for the next item is only ever assigned once per step.
	task automatic send_item(logic [COEFF_BITS-1:0] left, logic [COEFF_BITS-1:0] right,
			logic bend, logic wend);
		while (send_idle > 0 && $urandom_range(0, 99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {right, left};
		s_axis_tuser <= bend;
		s_axis_tlast <= wend;
		do
			@(posedge clk);
		while (!s_axis_tready);
		items_sent++;
		if (wend) begin
			win_mod = (win_mod + 1) % WINDOWS;
			if (win_mod == 0)
				frames_sent++;
		end
	endtask

	// A well-formed window. When close_band is clear, the last band is closed by the
	// window end alone.
	task automatic send_window(int nbands, int maxlen, bit loud, bit close_band);
		int     b;
		int     i;
		int     len;
		level_t lvl;
		logic   lastw;
		for (b = 0; b < nbands; b++) begin
			len = $urandom_range(1, maxlen);
			if ($urandom_range(0, 99) < 20)
				lvl = LVL_ZERO;
			else if (!loud)
				lvl = LVL_SOFT;
			else
				lvl = ($urandom_range(0, 3) == 0) ? LVL_EXTREME : LVL_FULL;
			for (i = 0; i < len; i++) begin
				lastw = (b == nbands - 1) && (i == len - 1);
				send_item(pick_coeff(lvl), pick_coeff(lvl),
					(i == len - 1) && (!lastw || close_band), lastw);
			end
		end
	endtask

	task automatic send_random_window();
		int r;
		int k;
		int i;
		r = $urandom_range(0, 99);
		if (r < 85) begin
			send_window($urandom_range(1, 17), ($urandom_range(0, 3) == 0) ? 3 : 1,
				$urandom_range(0, 2) == 0, $urandom_range(0, 9) != 0);
		end else if (r < 93) begin
			// Stray marks: band ends and window ends anywhere.
			k = $urandom_range(1, 12);
			for (i = 0; i < k; i++)
				send_item(pick_coeff(LVL_FULL), pick_coeff(LVL_FULL),
					1'($urandom_range(0, 1)),
					(i == k - 1) || ($urandom_range(0, 9) == 0));
		end else if (r < 97) begin
			// More band ends than the band counter can hold.
			send_window(34, 1, 1'b1, 1'b1);
		end else begin
			// A window that runs past the window length before its end mark.
			for (i = 0; i < WINDOW_LEN + 12; i++)
				send_item(pick_coeff(LVL_FULL), pick_coeff(LVL_FULL),
					$urandom_range(0, 9) == 0, i == WINDOW_LEN + 11);
		end
	endtask

	// Drop valid, then wait until every predicted group has come back and the window
	// pass has had time to finish.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (groups_open != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	task automatic write_setting(logic [7:0] bands, logic [7:0] cut, logic st);
		write_reg(CFG_MAX_BANDS, bands);
		write_reg(CFG_CUTOFF, cut);
		write_reg(CFG_STEREO, {7'd0, st});
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int p;
		int i;
		int start_items;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (p = 0; p < 8; p++) begin
			// Idling patterns: none, sender idle, receiver stalling, both lightly.
			case (p % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 77; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 77; end
				default: begin send_idle = 9; recv_stall = 9; end
			endcase

			// Phase 0 keeps the reset setting. The others cover all bands with stereo,
			// the smallest legal band count with everything cut off, the largest field
			// values, band counts that leave no voting band, and random settings.
			case (p)
				0: ;
				1: write_setting(8'd16, 8'd128, 1'b1);
				2: write_setting(8'd3, 8'd0, 1'b0);
				3: write_setting(8'd31, 8'd255, 1'b1);
				4: write_setting(8'd2, 8'd100, 1'b0);
				5: write_setting(8'd0, 8'($urandom_range(0, 255)), 1'b1);
				default: write_setting(8'($urandom_range(3, 16)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			endcase

			if (p == 0) begin
				// First window writes every band with corner values. The second is
				// empty, which makes every voting band swing and forces an onset; the
				// remaining windows carry band 0 only, so the final group is seven long.
				for (i = 0; i < MAX_BANDS; i++)
					send_item((i % 2 == 0) ? 24'h800000 : 24'h7FFFFF, pick_coeff(LVL_FULL),
						1'b1, i == MAX_BANDS - 1);
				send_item('0, pick_coeff(LVL_FULL), 1'b0, 1'b1);
				repeat (WINDOWS - 2) send_item(24'h7FFFFF, 24'h800000, 1'b1, 1'b1);
			end

			start_items = items_sent;
			while (items_sent - start_items < 20)
				send_random_window();
			while (win_mod != 0)
				send_window($urandom_range(1, 17), 1, 1'($urandom_range(0, 1)), 1'b1);
			wait_idle();
		end

		$display("Covered %0d coefficient transactions in %0d frames over eight register",
			items_sent, frames_sent);
		$display("settings and four idling patterns; %0d groups returned, %0d closed by onsets.",
			groups_seen, onset_groups);
		if (mismatches == 0)
			$display("short_window_onset_grouping: match");
		else
			$display("short_window_onset_grouping: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
src/swog_pkg.sv
src/swog_ctrl.sv
src/swog_dp.sv
src/short_window_onset_grouping.sv
sim/swog_group_checker.sv
sim/short_window_onset_grouping_tb.sv
